// File: hdl/cle_pkg.sv
// Shared types and constants for the cursor linked list engine.
// No dependencies; compile first.
package cle_pkg;

    localparam int OPC_W = 2;
    localparam int POS_W = 6;
    localparam int VAL_W = 8;
    localparam int CNT_W = 6;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2
    } op_t;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_INS_RD,
        S_INS_W1,
        S_INS_W2,
        S_DEL_W1,
        S_DEL_W2,
        S_TRV_RD,
        S_TRV,
        S_RESP
    } state_t;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] item;
        logic             has_item;
        logic [CNT_W-1:0] count;
        logic             last;
    } result_t;

endpackage

// File: hdl/cle_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on cle_pkg.
interface cle_in_if;
    logic                      valid;
    logic                      ready;
    logic [cle_pkg::OPC_W-1:0] opcode;
    logic [cle_pkg::POS_W-1:0] position;
    logic [cle_pkg::VAL_W-1:0] value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface cle_out_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic [cle_pkg::VAL_W-1:0] item;
    logic                      has_item;
    logic [cle_pkg::CNT_W-1:0] count;
    logic                      last;

    modport source (output valid, output status, output item, output has_item,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input item, input has_item,
                    input count, input last, output ready);
endinterface

// File: hdl/cursor_linked_list_engine.sv
// Cursor linked list engine: ordered byte list in a fixed node store.
// Requests arrive on req (opcode, position, value); results leave on rsp.
// One request is worked at a time; req.ready is high only while the sequencer idles.
// Insert or delete at position p walks down the link memory to its position, then writes
// back links; the walk reads one link per cycle on its read port.
// Traverse: one beat per element per cycle unless rsp stalls, last flagged on the final beat;
// an empty list gives one beat with has_item low.
// Insert, delete and bad requests give one beat each; status high marks an error.
// count carries the element count after the request.
// Results pass through an output register, so a new request is taken while a beat waits.
// If rsp stalls, the sequencer holds its place until the register frees.
// Reset empties the list and restores the free chain at once through per-entry valid
// bits in the link store; no clearing pass is needed.
// Depends on cle_pkg, cle_if, cle_link_ram, cle_data_ram, cle_seq.
module cursor_linked_list_engine #(
    parameter int DEPTH = 64
) (
    input logic        clk,
    input logic        rst_n,
    cle_in_if.sink     req,
    cle_out_if.source  rsp
);
    import cle_pkg::*;

    localparam int NW = $clog2(DEPTH);

    logic             out_free, out_load;
    result_t          res, out_res_reg;
    logic             out_vld_reg;
    logic             link_rd_en, link_wr_en, data_rd_en, data_wr_en;
    logic [NW-1:0]    link_rd_addr, link_rd_data, link_wr_addr, link_wr_data;
    logic [NW-1:0]    data_rd_addr, data_wr_addr;
    logic [VAL_W-1:0] data_rd_data, data_wr_data;

    cle_seq #(.DEPTH(DEPTH), .NW(NW)) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (req.valid),
        .in_ready     (req.ready),
        .in_op        (req.opcode),
        .in_pos       (req.position),
        .in_val       (req.value),
        .out_free     (out_free),
        .out_load     (out_load),
        .out_res      (res),
        .link_rd_en   (link_rd_en),
        .link_rd_addr (link_rd_addr),
        .link_rd_data (link_rd_data),
        .link_wr_en   (link_wr_en),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .data_rd_en   (data_rd_en),
        .data_rd_addr (data_rd_addr),
        .data_rd_data (data_rd_data),
        .data_wr_en   (data_wr_en),
        .data_wr_addr (data_wr_addr),
        .data_wr_data (data_wr_data)
    );

    cle_link_ram #(.DEPTH(DEPTH), .NW(NW)) u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data)
    );

    cle_data_ram #(.DEPTH(DEPTH), .NW(NW)) u_data (
        .clk     (clk),
        .rd_en   (data_rd_en),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd_data),
        .wr_en   (data_wr_en),
        .wr_addr (data_wr_addr),
        .wr_data (data_wr_data)
    );

    assign out_free = !out_vld_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.status   = out_res_reg.status;
    assign rsp.item     = out_res_reg.item;
    assign rsp.has_item = out_res_reg.has_item;
    assign rsp.count    = out_res_reg.count;
    assign rsp.last     = out_res_reg.last;

`ifndef SYNTHESIS
    // sequencer goes busy after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while sequencer busy");

    // only traverse beats continue past one beat
    a_nonlast_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last |-> rsp.has_item && !rsp.status)
        else $error("non-final beat without element");

    // error beats stand alone and carry no element
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.last && !rsp.has_item && (rsp.item == '0))
        else $error("malformed error beat");
`endif

endmodule

// File: hdl/cle_link_ram.sv
// Link store: one write port, one registered read port.
// Per-entry valid bits give the power-up free chain until an entry is written.
module cle_link_ram #(
    parameter int DEPTH = 64,
    parameter int NW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [NW-1:0] rd_addr,
    output logic [NW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [NW-1:0] wr_addr,
    input  logic [NW-1:0] wr_data
);
    import cle_pkg::*;

    logic [NW-1:0]    link_mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [NW-1:0]    q_reg;
    logic [NW-1:0]    q_addr_reg;
    logic             q_vld_reg;
    logic [NW-1:0]    init_link;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg      <= link_mem[rd_addr];
            q_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                q_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // power-up chain: n -> n+1, last node ends it
    assign init_link = (q_addr_reg >= NW'(DEPTH - 2)) ? '0 : q_addr_reg + NW'(1);
    assign rd_data   = q_vld_reg ? q_reg : init_link;

endmodule

// File: hdl/cle_data_ram.sv
// Data store: byte per node, one write port, one registered read port.
// Depends on cle_pkg.
module cle_data_ram #(
    parameter int DEPTH = 64,
    parameter int NW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [NW-1:0]             rd_addr,
    output logic [cle_pkg::VAL_W-1:0] rd_data,
    input  logic                      wr_en,
    input  logic [NW-1:0]             wr_addr,
    input  logic [cle_pkg::VAL_W-1:0] wr_data
);
    import cle_pkg::*;

    logic [VAL_W-1:0] data_mem [DEPTH];
    logic [VAL_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= data_mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

// File: hdl/cle_seq.sv
// Sequencer: walks the link store one node per cycle, then writes back links.
// Depends on cle_pkg; drives cle_link_ram and cle_data_ram.
module cle_seq #(
    parameter int DEPTH = 64,
    parameter int NW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [cle_pkg::OPC_W-1:0] in_op,
    input  logic [cle_pkg::POS_W-1:0] in_pos,
    input  logic [cle_pkg::VAL_W-1:0] in_val,
    input  logic                      out_free,
    output logic                      out_load,
    output cle_pkg::result_t          out_res,
    output logic                      link_rd_en,
    output logic [NW-1:0]             link_rd_addr,
    input  logic [NW-1:0]             link_rd_data,
    output logic                      link_wr_en,
    output logic [NW-1:0]             link_wr_addr,
    output logic [NW-1:0]             link_wr_data,
    output logic                      data_rd_en,
    output logic [NW-1:0]             data_rd_addr,
    input  logic [cle_pkg::VAL_W-1:0] data_rd_data,
    output logic                      data_wr_en,
    output logic [NW-1:0]             data_wr_addr,
    output logic [cle_pkg::VAL_W-1:0] data_wr_data
);
    import cle_pkg::*;

    localparam int CW  = $clog2(DEPTH - 1);
    localparam int CAP = DEPTH - 2;
    localparam int XW  = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [NW-1:0] HEAD = NW'(DEPTH - 1);
    localparam logic [NW-1:0] NIL  = '0;

    state_t           state_reg, state_next;
    op_t              op_reg;
    logic [VAL_W-1:0] val_reg;
    logic [POS_W-1:0] steps_reg;
    logic [NW-1:0]    cur_reg, prev_reg, nxt_reg, fresh_reg;
    logic [NW-1:0]    list_head_reg, free_head_reg;
    logic [CW-1:0]    count_reg, k_reg;
    logic             rd_pend_reg;
    logic             status_reg;

    logic [XW-1:0]    pos_x, cnt_x;
    logic             ins_bad, del_bad, trv_empty, acc_status;
    logic [NW-1:0]    nxt_now;
    logic             walk_more, trv_fin;
    logic [CNT_W-1:0] cnt_out;

    assign pos_x     = XW'(in_pos);
    assign cnt_x     = XW'(count_reg);
    assign ins_bad   = (pos_x == '0) || (pos_x > cnt_x + XW'(1)) || (cnt_x >= XW'(CAP));
    assign del_bad   = (pos_x == '0) || (pos_x > cnt_x);
    assign trv_empty = (count_reg == '0) || (list_head_reg == NIL);
    assign nxt_now   = rd_pend_reg ? link_rd_data : nxt_reg;
    assign walk_more = (steps_reg != '0);
    assign trv_fin   = ((k_reg + CW'(1)) == count_reg) || (link_rd_data == NIL);
    assign cnt_out   = CNT_W'(count_reg);

    always_comb
    begin
        case (op_t'(in_op))
            OP_INSERT:   acc_status = ins_bad ? ST_ERR : ST_OK;
            OP_DELETE:   acc_status = del_bad ? ST_ERR : ST_OK;
            OP_TRAVERSE: acc_status = ST_OK;
            default:     acc_status = ST_ERR;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op_t'(in_op))
                        OP_INSERT:   state_next = ins_bad ? S_RESP : S_WALK;
                        OP_DELETE:   state_next = del_bad ? S_RESP : S_WALK;
                        OP_TRAVERSE: state_next = trv_empty ? S_RESP : S_TRV_RD;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_WALK:
            begin
                if (!walk_more)
                begin
                    state_next = (op_reg == OP_INSERT) ? S_INS_RD : S_DEL_W1;
                end
            end
            S_INS_RD: state_next = S_INS_W1;
            S_INS_W1: state_next = S_INS_W2;
            S_INS_W2: state_next = S_RESP;
            S_DEL_W1: state_next = S_DEL_W2;
            S_DEL_W2: state_next = S_RESP;
            S_TRV_RD: state_next = S_TRV;
            S_TRV:
            begin
                if (out_free && trv_fin)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_load     = 1'b0;
        out_res      = '{status: status_reg, item: '0, has_item: 1'b0,
                         count: cnt_out, last: 1'b1};
        link_rd_en   = 1'b0;
        link_rd_addr = nxt_now;
        link_wr_en   = 1'b0;
        link_wr_addr = cur_reg;
        link_wr_data = nxt_reg;
        data_rd_en   = 1'b0;
        data_rd_addr = link_rd_data;
        data_wr_en   = 1'b0;
        data_wr_addr = free_head_reg;
        data_wr_data = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_WALK:
            begin
                link_rd_en = walk_more;
            end
            S_INS_RD:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = free_head_reg;
                data_wr_en   = 1'b1;
            end
            S_INS_W1:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = fresh_reg;
                link_wr_data = nxt_reg;
            end
            S_INS_W2:
            begin
                link_wr_en   = (cur_reg != HEAD);
                link_wr_addr = cur_reg;
                link_wr_data = fresh_reg;
            end
            S_DEL_W1:
            begin
                link_wr_en   = (prev_reg != HEAD);
                link_wr_addr = prev_reg;
                link_wr_data = nxt_reg;
            end
            S_DEL_W2:
            begin
                link_wr_en   = 1'b1;
                link_wr_addr = cur_reg;
                link_wr_data = free_head_reg;
            end
            S_TRV_RD:
            begin
                link_rd_en   = 1'b1;
                link_rd_addr = list_head_reg;
                data_rd_en   = 1'b1;
                data_rd_addr = list_head_reg;
            end
            S_TRV:
            begin
                out_load     = out_free;
                out_res      = '{status: ST_OK, item: data_rd_data, has_item: 1'b1,
                                 count: cnt_out, last: trv_fin};
                link_rd_en   = out_free && !trv_fin;
                link_rd_addr = link_rd_data;
                data_rd_en   = out_free && !trv_fin;
            end
            S_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_pend_reg   <= 1'b0;
            list_head_reg <= NIL;
            free_head_reg <= NW'(1);
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:   rd_pend_reg <= 1'b0;
                S_WALK:   rd_pend_reg <= walk_more;
                S_INS_W1: free_head_reg <= link_rd_data;
                S_INS_W2:
                begin
                    if (cur_reg == HEAD)
                    begin
                        list_head_reg <= fresh_reg;
                    end
                    count_reg <= count_reg + CW'(1);
                end
                S_DEL_W1:
                begin
                    if (prev_reg == HEAD)
                    begin
                        list_head_reg <= nxt_reg;
                    end
                end
                S_DEL_W2:
                begin
                    free_head_reg <= cur_reg;
                    count_reg     <= count_reg - CW'(1);
                end
                default:  rd_pend_reg <= rd_pend_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_reg     <= op_t'(in_op);
                    val_reg    <= in_val;
                    status_reg <= acc_status;
                    steps_reg  <= (op_t'(in_op) == OP_INSERT) ? in_pos - POS_W'(1) : in_pos;
                    cur_reg    <= HEAD;
                    prev_reg   <= HEAD;
                    nxt_reg    <= list_head_reg;
                    k_reg      <= '0;
                end
            end
            S_WALK:
            begin
                if (walk_more)
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= nxt_now;
                    steps_reg <= steps_reg - POS_W'(1);
                end
                else
                begin
                    nxt_reg <= nxt_now;
                end
            end
            S_INS_RD: fresh_reg <= free_head_reg;
            S_TRV:
            begin
                if (out_free)
                begin
                    k_reg <= k_reg + CW'(1);
                end
            end
            default:  val_reg <= val_reg;
        endcase
    end

endmodule
